// ===== design/utrd_pkg.sv =====
// shared constants, types and helpers for the uart transmit ring
// no dependencies
`timescale 1ns / 1ps

package utrd_pkg;

   localparam int RING_DEPTH = 4096;
   localparam int BURST_LEN  = 16;
   localparam int RING_AW    = $clog2(RING_DEPTH);
   localparam int BURST_CW   = $clog2(BURST_LEN + 1);

   localparam logic [7:0] NL_CHAR = 8'h0A;
   localparam logic [7:0] CR_CHAR = 8'h0D;

   localparam logic ACT_PUT  = 1'b0;
   localparam logic ACT_KICK = 1'b1;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_PUSH_CR,
      ST_PUSH_DATA,
      ST_DRAIN
   } state_type;

   function automatic logic [RING_AW-1:0] ring_next(input logic [RING_AW-1:0] idx);
      logic [RING_AW-1:0] res;
      if (idx == RING_AW'(RING_DEPTH - 1)) begin
         res = '0;
      end else begin
         res = idx + RING_AW'(1);
      end
      return res;
   endfunction

endpackage

// ===== design/utrd_ram.sv =====
// generic single write port, single read port ram with registered read data
// no dependencies
`timescale 1ns / 1ps

module utrd_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4096
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/uart_tx_ring_drop_oldest.sv =====
// Transmit ring in front of a UART FIFO. A put request (action 0) queues its byte, a newline
// being preceded by a carriage return; when the ring is full the oldest byte is dropped. If the
// request reports the UART transmit FIFO empty, up to BURST_LEN queued bytes are then sent in
// order on the rsp channel, the final one flagged by rsp_last_byte. With csr uart_present at 0
// requests are taken and ignored. After a request is accepted req_stall stays high while the
// ring is written and, when the FIFO is reported empty, while the burst is read out of the
// ring and sent, longer while rsp_stall holds a byte; the idle state then takes the next
// request. The ring memory returns one byte per cycle unless rsp_stall holds a byte. The ring
// memory is not cleared at reset; only queued entries are ever read.
// depends on utrd_pkg and utrd_ram
`timescale 1ns / 1ps

module uart_tx_ring_drop_oldest (
   input  logic       clock,
   input  logic       reset,
   input  logic       csr_write_enable,
   input  logic       csr_write_data,
   input  logic       req_valid,
   output logic       req_stall,
   input  logic       req_action,
   input  logic [7:0] req_data_byte,
   input  logic       req_tx_fifo_empty,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic [7:0] rsp_tx_byte,
   output logic       rsp_last_byte
);

   utrd_pkg::state_type state_ff, state_in;

   logic                           present_ff;
   logic [utrd_pkg::RING_AW-1:0]   wr_ff, wr_in;
   logic [utrd_pkg::RING_AW-1:0]   rd_ff, rd_in;
   logic [utrd_pkg::BURST_CW-1:0]  count_ff, count_in;
   logic [7:0]                     data_ff;
   logic                           fifo_empty_ff;
   logic                           pend_ff, pend_in;
   logic                           pend_last_ff, pend_last_in;
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [7:0]                     rsp_byte_ff;
   logic                           rsp_last_ff;

   logic                           accept;
   logic                           push_en;
   logic [7:0]                     push_byte;
   logic                           drain_en;
   logic                           more;
   logic                           issue;
   logic                           load;
   logic                           drain_done;
   logic [7:0]                     ram_rd_data;
   logic [utrd_pkg::RING_AW-1:0]   wr_next;

   assign accept     = req_valid && !req_stall;
   assign wr_next    = utrd_pkg::ring_next(wr_ff);
   assign more       = (count_ff != utrd_pkg::BURST_CW'(utrd_pkg::BURST_LEN)) && (rd_ff != wr_ff);
   assign load       = pend_ff && (!rsp_valid_ff || !rsp_stall);
   assign issue      = drain_en && more && (!pend_ff || load);
   assign drain_done = !more && !pend_ff;

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         utrd_pkg::ST_IDLE: begin
            if (accept && present_ff) begin
               if (req_action == utrd_pkg::ACT_PUT) begin
                  state_in = (req_data_byte == utrd_pkg::NL_CHAR) ?
                             utrd_pkg::ST_PUSH_CR : utrd_pkg::ST_PUSH_DATA;
               end else if (req_tx_fifo_empty) begin
                  state_in = utrd_pkg::ST_DRAIN;
               end
            end
         end
         utrd_pkg::ST_PUSH_CR: begin
            state_in = utrd_pkg::ST_PUSH_DATA;
         end
         utrd_pkg::ST_PUSH_DATA: begin
            state_in = fifo_empty_ff ? utrd_pkg::ST_DRAIN : utrd_pkg::ST_IDLE;
         end
         utrd_pkg::ST_DRAIN: begin
            if (drain_done) begin
               state_in = utrd_pkg::ST_IDLE;
            end
         end
         default: state_in = utrd_pkg::ST_IDLE;
      endcase
   end

   // state decode
   always_comb begin
      req_stall = 1'b1;
      push_en   = 1'b0;
      push_byte = data_ff;
      drain_en  = 1'b0;
      unique case (state_ff)
         utrd_pkg::ST_IDLE: begin
            req_stall = 1'b0;
         end
         utrd_pkg::ST_PUSH_CR: begin
            push_en   = 1'b1;
            push_byte = utrd_pkg::CR_CHAR;
         end
         utrd_pkg::ST_PUSH_DATA: begin
            push_en = 1'b1;
         end
         utrd_pkg::ST_DRAIN: begin
            drain_en = 1'b1;
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   // ring pointers, burst count and read pipeline
   always_comb begin
      wr_in        = wr_ff;
      rd_in        = rd_ff;
      count_in     = count_ff;
      pend_in      = pend_ff;
      pend_last_in = pend_last_ff;
      rsp_valid_in = rsp_valid_ff;

      if (!drain_en) begin
         count_in = '0;
      end
      if (push_en) begin
         wr_in = wr_next;
         // full ring drops the oldest byte
         if (wr_next == rd_ff) begin
            rd_in = utrd_pkg::ring_next(rd_ff);
         end
      end
      if (load) begin
         pend_in = 1'b0;
      end
      if (issue) begin
         rd_in        = utrd_pkg::ring_next(rd_ff);
         count_in     = count_ff + utrd_pkg::BURST_CW'(1);
         pend_in      = 1'b1;
         pend_last_in = (count_ff == utrd_pkg::BURST_CW'(utrd_pkg::BURST_LEN - 1)) ||
                        (utrd_pkg::ring_next(rd_ff) == wr_ff);
      end
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= utrd_pkg::ST_IDLE;
         present_ff   <= 1'b0;
         wr_ff        <= '0;
         rd_ff        <= '0;
         count_ff     <= '0;
         pend_ff      <= 1'b0;
         pend_last_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         wr_ff        <= wr_in;
         rd_ff        <= rd_in;
         count_ff     <= count_in;
         pend_ff      <= pend_in;
         pend_last_ff <= pend_last_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_write_enable) begin
            present_ff <= csr_write_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         data_ff       <= req_data_byte;
         fifo_empty_ff <= req_tx_fifo_empty;
      end
      if (load) begin
         rsp_byte_ff <= ram_rd_data;
         rsp_last_ff <= pend_last_ff;
      end
   end

   utrd_ram #(
      .WIDTH (8),
      .DEPTH (utrd_pkg::RING_DEPTH)
   ) u_ring (
      .clock   (clock),
      .wr_en   (push_en),
      .wr_addr (wr_ff),
      .wr_data (push_byte),
      .rd_en   (issue),
      .rd_addr (rd_ff),
      .rd_data (ram_rd_data)
   );

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_tx_byte   = rsp_byte_ff;
   assign rsp_last_byte = rsp_last_ff;

`ifndef NO_ASSERTIONS
   a_pend_only_in_drain: assert property (@(posedge clock) disable iff (reset)
      pend_ff |-> state_ff == utrd_pkg::ST_DRAIN)
      else $error("read pending outside drain");

   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= utrd_pkg::BURST_CW'(utrd_pkg::BURST_LEN))
      else $error("burst count overrun");

   a_push_not_empty: assert property (@(posedge clock) disable iff (reset)
      push_en |=> wr_ff != rd_ff)
      else $error("ring empty after push");

   a_last_loaded: assert property (@(posedge clock) disable iff (reset)
      load && pend_last_ff |=> rsp_valid && rsp_last_byte)
      else $error("last flag lost");
`endif

endmodule

// ===== sim/tb_top.sv =====
// self-checking bench for uart_tx_ring_drop_oldest: random and directed put/kick requests,
// a ring predictor and in-order comparison of every transmitted byte
// depends on utrd_pkg and the design files under design/
`timescale 1ns / 1ps

module tb_top;

   localparam int SETTLE_CYCLES = 40;
   localparam int WATCHDOG_LIMIT = 3000;

   typedef struct packed {
      bit       action;
      bit [7:0] data_byte;
      bit       tx_fifo_empty;
      bit       hold_for_drain;
   } request_type;

   typedef struct packed {
      bit [7:0] tx_byte;
      bit       last_byte;
   } tx_beat_type;

   logic       clock = 1'b0;
   logic       reset = 1'b1;
   logic       csr_write_enable = 1'b0;
   logic       csr_write_data = 1'b0;
   logic       req_valid = 1'b0;
   logic       req_stall;
   logic       req_action = 1'b0;
   logic [7:0] req_data_byte = 8'h00;
   logic       req_tx_fifo_empty = 1'b0;
   logic       rsp_valid;
   logic       rsp_stall = 1'b0;
   logic [7:0] rsp_tx_byte;
   logic       rsp_last_byte;

   request_type queued_requests[$];
   tx_beat_type pending_tx_bytes[$];

   // predictor state
   bit [7:0]                   ring_mem[utrd_pkg::RING_DEPTH];
   bit [utrd_pkg::RING_AW-1:0] ring_wr = '0;
   bit [utrd_pkg::RING_AW-1:0] ring_rd = '0;
   bit                         uart_on = 1'b0;

   int fail_count = 0;
   int req_idle_level = 0;
   int rsp_idle_level = 0;
   int req_gap_left = 0;
   int rsp_stall_left = 0;
   int quiet_cycles = 0;

   uart_tx_ring_drop_oldest dut (
      .clock             (clock),
      .reset             (reset),
      .csr_write_enable  (csr_write_enable),
      .csr_write_data    (csr_write_data),
      .req_valid         (req_valid),
      .req_stall         (req_stall),
      .req_action        (req_action),
      .req_data_byte     (req_data_byte),
      .req_tx_fifo_empty (req_tx_fifo_empty),
      .rsp_valid         (rsp_valid),
      .rsp_stall         (rsp_stall),
      .rsp_tx_byte       (rsp_tx_byte),
      .rsp_last_byte     (rsp_last_byte)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   function automatic bit [utrd_pkg::RING_AW-1:0] ring_step(
         input bit [utrd_pkg::RING_AW-1:0] idx);
      return (idx == utrd_pkg::RING_AW'(utrd_pkg::RING_DEPTH - 1)) ?
             '0 : idx + utrd_pkg::RING_AW'(1);
   endfunction

   task automatic ring_enqueue(input bit [7:0] value);
      bit [utrd_pkg::RING_AW-1:0] after;
      after = ring_step(ring_wr);
      // full ring drops its oldest byte
      if (after == ring_rd) begin
         ring_rd = ring_step(ring_rd);
      end
      ring_mem[ring_wr] = value;
      ring_wr = after;
   endtask

   task automatic apply_request_to_ring(input bit action, input bit [7:0] data_byte,
                                        input bit tx_fifo_empty);
      int sent;
      tx_beat_type beat;
      sent = 0;
      if (uart_on) begin
         if (action == utrd_pkg::ACT_PUT) begin
            if (data_byte == utrd_pkg::NL_CHAR) begin
               ring_enqueue(utrd_pkg::CR_CHAR);
            end
            ring_enqueue(data_byte);
         end
         if (tx_fifo_empty) begin
            while (sent < utrd_pkg::BURST_LEN && ring_rd != ring_wr) begin
               beat.tx_byte = ring_mem[ring_rd];
               ring_rd = ring_step(ring_rd);
               sent++;
               beat.last_byte = (sent == utrd_pkg::BURST_LEN || ring_rd == ring_wr);
               pending_tx_bytes.push_back(beat);
            end
         end
      end
   endtask

   function automatic int pick_gap(input int level);
      int r;
      r = $urandom_range(0, 99);
      if (level == 0 || r < 60) begin
         return 0;
      end else if (r < 93) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(10, 60);
   endfunction

   function automatic request_type make_request(input int put_pct, input int nl_pct,
                                                input int empty_pct, input int hold_pct);
      request_type rq;
      rq.action = ($urandom_range(0, 99) < put_pct) ? utrd_pkg::ACT_PUT : utrd_pkg::ACT_KICK;
      rq.data_byte = ($urandom_range(0, 99) < nl_pct) ? utrd_pkg::NL_CHAR : 8'($urandom);
      rq.tx_fifo_empty = ($urandom_range(0, 99) < empty_pct);
      rq.hold_for_drain = ($urandom_range(0, 99) < hold_pct);
      return rq;
   endfunction

   function automatic request_type fixed_request(input bit action, input bit [7:0] data_byte,
                                                 input bit tx_fifo_empty);
      request_type rq;
      rq.action = action;
      rq.data_byte = data_byte;
      rq.tx_fifo_empty = tx_fifo_empty;
      rq.hold_for_drain = 1'b0;
      return rq;
   endfunction

   // request driver
   always @(posedge clock) begin : driver
      request_type nxt;
      if (reset) begin
         req_valid <= 1'b0;
         req_gap_left = 0;
      end else begin
         if (req_valid && !req_stall) begin
            apply_request_to_ring(req_action, req_data_byte, req_tx_fifo_empty);
         end
         if (!req_valid || !req_stall) begin
            if (req_gap_left > 0) begin
               req_gap_left--;
               req_valid <= 1'b0;
            end else if (queued_requests.size() != 0 &&
                         !(queued_requests[0].hold_for_drain &&
                           (req_valid || pending_tx_bytes.size() != 0))) begin
               nxt = queued_requests.pop_front();
               req_action <= nxt.action;
               req_data_byte <= nxt.data_byte;
               req_tx_fifo_empty <= nxt.tx_fifo_empty;
               req_valid <= 1'b1;
               req_gap_left = pick_gap(req_idle_level);
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // result monitor
   always @(posedge clock) begin : monitor
      tx_beat_type want;
      int len;
      if (reset) begin
         rsp_stall <= 1'b0;
         rsp_stall_left = 0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (pending_tx_bytes.size() == 0) begin
               $error("unexpected result: tx_byte %02h last_byte %0b", rsp_tx_byte,
                      rsp_last_byte);
               fail_count++;
            end else begin
               want = pending_tx_bytes.pop_front();
               if (rsp_tx_byte !== want.tx_byte) begin
                  $error("tx_byte mismatch: expected %02h actual %02h", want.tx_byte,
                         rsp_tx_byte);
                  fail_count++;
               end
               if (rsp_last_byte !== want.last_byte) begin
                  $error("last_byte mismatch: expected %0b actual %0b", want.last_byte,
                         rsp_last_byte);
                  fail_count++;
               end
            end
         end
         if (rsp_stall_left > 0) begin
            rsp_stall_left--;
            rsp_stall <= 1'b1;
         end else begin
            len = pick_gap(rsp_idle_level);
            rsp_stall <= (len > 0);
            rsp_stall_left = (len > 0) ? len - 1 : 0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          csr_write_enable) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic settle_ring();
      do begin
         @(posedge clock);
      end while (queued_requests.size() != 0 || req_valid || pending_tx_bytes.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_uart_present(input bit value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data <= value;
      uart_on = value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
   endtask

   task automatic queue_random(input int count, input int put_pct, input int nl_pct,
                               input int empty_pct, input int hold_pct);
      for (int i = 0; i < count; i++) begin
         queued_requests.push_back(make_request(put_pct, nl_pct, empty_pct, hold_pct));
      end
   endtask

   initial begin
      request_type rq;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // uart absent after reset: everything ignored
      queued_requests.push_back(fixed_request(utrd_pkg::ACT_PUT, 8'h41, 1'b1));
      queued_requests.push_back(fixed_request(utrd_pkg::ACT_PUT, utrd_pkg::NL_CHAR, 1'b1));
      queued_requests.push_back(fixed_request(utrd_pkg::ACT_KICK, 8'h00, 1'b1));
      settle_ring();

      write_uart_present(1'b1);
      queued_requests.push_back(fixed_request(utrd_pkg::ACT_KICK, 8'hFF, 1'b1));
      queued_requests.push_back(fixed_request(utrd_pkg::ACT_PUT, 8'h00, 1'b0));
      queued_requests.push_back(fixed_request(utrd_pkg::ACT_PUT, 8'hFF, 1'b0));
      queued_requests.push_back(fixed_request(utrd_pkg::ACT_PUT, utrd_pkg::NL_CHAR, 1'b0));
      queued_requests.push_back(fixed_request(utrd_pkg::ACT_PUT, utrd_pkg::CR_CHAR, 1'b1));
      queued_requests.push_back(fixed_request(utrd_pkg::ACT_PUT, 8'h7F, 1'b1));
      queued_requests.push_back(fixed_request(utrd_pkg::ACT_PUT, utrd_pkg::NL_CHAR, 1'b1));
      // 20 bytes queued, then three kicks: full burst, remainder and one on an empty ring
      for (int i = 0; i < 10; i++) begin
         queued_requests.push_back(fixed_request(utrd_pkg::ACT_PUT, utrd_pkg::NL_CHAR, 1'b0));
      end
      queued_requests.push_back(fixed_request(utrd_pkg::ACT_KICK, 8'h55, 1'b1));
      queued_requests.push_back(fixed_request(utrd_pkg::ACT_KICK, 8'hAA, 1'b1));
      queued_requests.push_back(fixed_request(utrd_pkg::ACT_KICK, 8'h80, 1'b1));
      settle_ring();

      write_uart_present(1'b0);
      queue_random(8, 70, 20, 50, 0);
      settle_ring();
      write_uart_present(1'b1);

      // main random mix, first stretch without idling
      queue_random(100, 70, 15, 35, 2);
      rq = make_request(100, 0, 0, 0);
      rq.hold_for_drain = 1'b1;
      queued_requests.push_back(rq);
      queue_random(170, 70, 15, 35, 2);
      while (queued_requests.size() > 170) @(posedge clock);
      req_idle_level = 1;
      rsp_idle_level = 1;
      settle_ring();

      // long run of puts with no drain, then drain it over several bursts
      req_idle_level = 0;
      queue_random(60, 100, 50, 0, 0);
      for (int i = 0; i < 10; i++) begin
         queued_requests.push_back(fixed_request(utrd_pkg::ACT_KICK, 8'($urandom), 1'b1));
      end
      while (queued_requests.size() > 10) @(posedge clock);
      req_idle_level = 1;
      settle_ring();

      write_uart_present(1'b0);
      queue_random(5, 70, 20, 50, 0);
      settle_ring();
      write_uart_present(1'b1);
      queue_random(40, 60, 20, 50, 5);
      settle_ring();

      if (fail_count == 0 && pending_tx_bytes.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
